>>> rtl/core/rtpb_pkg.sv
// rtpb_pkg: shared types and constants of the rtp reorder buffer
// request/response beat layouts, status codes, controller states and
// the command/status bundles between controller and datapath; no dependencies
package rtpb_pkg;

  // packet format constants
  localparam logic [15:0] HDR_LEN      = 16'd12;
  localparam logic [15:0] MARKER_LEN   = 16'd16;
  localparam logic [31:0] EMPTY_MARKER = 32'h0068_3400;
  localparam logic [15:0] MAX_LEN_RST  = 16'd2048;

  // register index of max_packet_len (paddr[2])
  localparam logic REG_MAX_LEN = 1'b0;

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_RESEND = 2'd2,
    REQ_FLUSH  = 2'd3
  } req_type_t;

  typedef enum logic [3:0] {
    STAT_STORED    = 4'd0,
    STAT_IGNORED   = 4'd1,
    STAT_BAD_LEN   = 4'd2,
    STAT_NONE      = 4'd3,
    STAT_DELIVERED = 4'd4,
    STAT_SKIPPED   = 4'd5,
    STAT_NO_RESEND = 4'd6,
    STAT_RESEND    = 4'd7,
    STAT_FLUSHED   = 4'd8
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] seq_in;
    logic        use_seq;
    logic [15:0] data_len;
    logic [31:0] marker_word;
    logic [63:0] rtp_time;
    logic [63:0] ntp_time;
    logic [15:0] payload_tag;
    logic        never_wait;
    logic        flush_to_empty;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] out_seq;
    logic [63:0] out_rtp_time;
    logic [63:0] out_ntp_time;
    logic [15:0] out_length;
    logic [15:0] out_tag;
    logic [15:0] resend_first;
    logic [15:0] resend_count;
  } rsp_t;

  // one stored packet
  typedef struct packed {
    logic [15:0] seq;
    logic [63:0] rtp;
    logic [63:0] ntp;
    logic [15:0] length;
    logic [15:0] tag;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SCAN
  } fsm_state_t;

  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic commit;
    logic scan_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_resend;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/rtpb_ifs.sv
// rtpb_req_if / rtpb_rsp_if: valid/ready channels of the reorder buffer
// payloads are the beat structs of rtpb_pkg
interface rtpb_req_if;
  logic          valid;
  logic          ready;
  rtpb_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtpb_rsp_if;
  logic          valid;
  logic          ready;
  rtpb_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/rtpb_ctrl.sv
// rtpb_ctrl: sequencing state machine of the reorder buffer
// issues capture, slot read, scan and commit commands; uses rtpb_pkg
module rtpb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtpb_pkg::dp_stat_t  stat,
  output rtpb_pkg::ctrl_cmd_t cmd
);

  rtpb_pkg::fsm_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtpb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      rtpb_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = rtpb_pkg::ST_READ;
      end
      rtpb_pkg::ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = stat.is_resend ? rtpb_pkg::ST_SCAN : rtpb_pkg::ST_EXEC;
      end
      rtpb_pkg::ST_EXEC: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = rtpb_pkg::ST_IDLE;
        end
      end
      rtpb_pkg::ST_SCAN: begin
        if (!stat.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = rtpb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rtpb_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/rtpb_dp.sv
// rtpb_dp: datapath of the reorder buffer: slot memory, valid bits,
// head/tail window, slot index unit, gap scan and result register; uses rtpb_pkg
module rtpb_dp #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rtpb_pkg::req_t      in_data,
  input  logic [15:0]         max_len,
  input  rtpb_pkg::ctrl_cmd_t cmd,
  output rtpb_pkg::dp_stat_t  stat,
  input  logic                out_ready,
  output logic                out_valid,
  output rtpb_pkg::rsp_t      out_data
);

  localparam int AW = $clog2(DEPTH);
  // reciprocal for seq mod DEPTH, exact for 16-bit sequence numbers
  localparam longint unsigned RECIP = ((64'd1 << 32) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
  localparam logic [15:0] DEPTH16 = 16'(DEPTH);

  rtpb_pkg::slot_t mem [DEPTH];
  rtpb_pkg::slot_t rd_r;

  rtpb_pkg::req_t req_r;
  logic [15:0]    key_r, quot_r;
  logic [AW-1:0]  idx_r;
  logic [15:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic           empty_r, empty_nxt;
  logic [DEPTH-1:0] filled_r, filled_nxt;
  logic [15:0]    scan_seq_r;
  logic [AW-1:0]  scan_idx_r;
  logic           out_valid_r;
  rtpb_pkg::rsp_t out_r, rsp;
  logic           wr_en;

  logic [15:0] key_sel;
  logic [48:0] prod;
  logic [15:0] rem;
  logic [AW-1:0] idx_calc;

  // slot index: key sequence and its quotient at capture, remainder at read
  assign key_sel  = (in_data.req_type == rtpb_pkg::REQ_ENQ && in_data.use_seq) ?
                    in_data.seq_in : head_r;
  assign prod     = 49'(key_sel) * 49'(RECIP);
  assign rem      = key_r - 16'(32'(quot_r) * 32'(DEPTH));
  assign idx_calc = rem[AW-1:0];

  // gap scan status
  logic [15:0] scan_diff;
  logic        scan_before;
  assign scan_diff   = scan_seq_r - tail_r;
  assign scan_before = scan_diff[15];

  assign stat.is_resend = (req_r.req_type == rtpb_pkg::REQ_RESEND);
  assign stat.scan_done = !scan_before || filled_r[scan_idx_r];
  assign stat.out_free  = !out_valid_r || out_ready;

  // enqueue and dequeue terms
  logic        bad_len, is_marker, late, far, dup, tail_gt;
  logic [15:0] head_dist, far_diff, tail_tmp, tail_diff, cnt;
  logic        cnt_pos, cnt_lt;
  always_comb begin
    bad_len   = (req_r.data_len < rtpb_pkg::HDR_LEN) || (req_r.data_len > max_len);
    is_marker = (req_r.data_len == rtpb_pkg::MARKER_LEN) &&
                (req_r.marker_word == rtpb_pkg::EMPTY_MARKER);
    head_dist = key_r - head_r;
    late      = !empty_r && head_dist[15];
    far_diff  = key_r - (head_r + DEPTH16);
    far       = !far_diff[15];
    dup       = !far && filled_r[idx_r] && (rd_r.seq == key_r);
    tail_tmp  = far ? key_r - 16'd1 : tail_r;
    tail_diff = key_r - tail_tmp;
    tail_gt   = (tail_diff != 16'd0) && !tail_diff[15];
    cnt       = tail_r - head_r + 16'd1;
    cnt_pos   = !cnt[15] && (cnt != 16'd0);
    cnt_lt    = cnt < DEPTH16;
  end

  // request execution
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    filled_nxt = filled_r;
    wr_en      = 1'b0;
    rsp        = '0;
    case (req_r.req_type)
      rtpb_pkg::REQ_ENQ: begin
        if (bad_len) begin
          rsp.status = rtpb_pkg::STAT_BAD_LEN;
        end else if (is_marker || late || dup) begin
          rsp.status = rtpb_pkg::STAT_IGNORED;
        end else begin
          if (far) filled_nxt = '0;
          filled_nxt[idx_r] = 1'b1;
          wr_en      = 1'b1;
          head_nxt   = (far || empty_r) ? key_r : head_r;
          tail_nxt   = (empty_r || tail_gt) ? key_r : tail_tmp;
          empty_nxt  = 1'b0;
          rsp.status = rtpb_pkg::STAT_STORED;
        end
      end
      rtpb_pkg::REQ_DEQ: begin
        if (empty_r || !cnt_pos) begin
          rsp.status = rtpb_pkg::STAT_NONE;
        end else if (!req_r.never_wait && !filled_r[idx_r] && cnt_lt) begin
          rsp.status = rtpb_pkg::STAT_NONE;
        end else begin
          head_nxt = head_r + 16'd1;
          if (!filled_r[idx_r]) begin
            rsp.status = rtpb_pkg::STAT_SKIPPED;
          end else begin
            filled_nxt[idx_r] = 1'b0;
            rsp.status       = rtpb_pkg::STAT_DELIVERED;
            rsp.out_seq      = rd_r.seq;
            rsp.out_rtp_time = rd_r.rtp;
            rsp.out_ntp_time = rd_r.ntp;
            rsp.out_length   = rd_r.length;
            rsp.out_tag      = rd_r.tag;
          end
        end
      end
      rtpb_pkg::REQ_RESEND: begin
        if (scan_seq_r == head_r) begin
          rsp.status = rtpb_pkg::STAT_NO_RESEND;
        end else begin
          rsp.status       = rtpb_pkg::STAT_RESEND;
          rsp.resend_first = head_r;
          rsp.resend_count = scan_seq_r - head_r;
        end
      end
      rtpb_pkg::REQ_FLUSH: begin
        filled_nxt = '0;
        if (req_r.flush_to_empty) begin
          empty_nxt = 1'b1;
        end else begin
          head_nxt = req_r.seq_in;
          tail_nxt = req_r.seq_in - 16'd1;
        end
        rsp.status = rtpb_pkg::STAT_FLUSHED;
      end
      default: rsp.status = rtpb_pkg::STAT_NONE;
    endcase
  end

  // window state and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        empty_r  <= empty_nxt;
        filled_r <= filled_nxt;
      end
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // request capture, index and scan registers, result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_data;
      key_r  <= key_sel;
      quot_r <= prod[47:32];
    end
    if (cmd.mem_rd) begin
      idx_r      <= idx_calc;
      scan_seq_r <= head_r;
      scan_idx_r <= idx_calc;
    end else if (cmd.scan_step) begin
      scan_seq_r <= scan_seq_r + 16'd1;
      scan_idx_r <= (scan_idx_r == AW'(DEPTH - 1)) ? '0 : scan_idx_r + AW'(1);
    end
    if (cmd.commit) out_r <= rsp;
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en && cmd.commit) begin
      mem[idx_r] <= '{seq: key_r, rtp: req_r.rtp_time, ntp: req_r.ntp_time,
                      length: req_r.data_len - rtpb_pkg::HDR_LEN,
                      tag: req_r.payload_tag};
    end
    if (cmd.mem_rd) rd_r <= mem[idx_calc];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/rtp_reorder_buffer.sv
// rtp_reorder_buffer: one request beat in, one result beat out per request.
// each request is captured, its slot read from the slot memory, then executed and
// committed to the result register; a resend query first scans the run of
// missing slots one a cycle. a new request is taken only once the last one has
// committed, and a waiting result stalls the next commit.
// reset: synchronous, active low; slot valid bits clear together, no sweep.
module rtp_reorder_buffer #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  rtpb_req_if.sink    in_if,
  rtpb_rsp_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]         max_len_r;
  rtpb_pkg::ctrl_cmd_t cmd;
  rtpb_pkg::dp_stat_t  stat;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= rtpb_pkg::MAX_LEN_RST;
    end else if (psel && penable && pwrite && paddr[2] == rtpb_pkg::REG_MAX_LEN) begin
      max_len_r <= pwdata[15:0];
    end
  end
  assign prdata = (paddr[2] == rtpb_pkg::REG_MAX_LEN) ? {16'd0, max_len_r} : 32'd0;

  rtpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtpb_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_if.data),
    .max_len   (max_len_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_data  (out_if.data)
  );

`ifndef ASSERT_OFF
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> stat.out_free) else $error("commit into a full result register");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("more than one command at once");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready) else $error("request taken while busy");
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_if.valid) else $error("commit gave no result beat");
`endif

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for rtp_reorder_buffer (sequence reorder store)
// drives request beats and apb register writes, predicts every result beat;
// depends on rtpb_pkg, rtpb_req_if / rtpb_rsp_if and the rtl top level
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = 32;
  localparam int IDLE_WAIT = 60;
  localparam logic [2:0] ADDR_MAX_LEN = 3'd0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rtpb_req_if req_ch ();
  rtpb_rsp_if rsp_ch ();

  rtp_reorder_buffer #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .in_if(req_ch), .out_if(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the reorder store
  logic        shd_filled [DEPTH];
  logic [15:0] shd_seq    [DEPTH];
  logic [63:0] shd_rtp    [DEPTH];
  logic [63:0] shd_ntp    [DEPTH];
  logic [15:0] shd_len    [DEPTH];
  logic [15:0] shd_tag    [DEPTH];
  logic [15:0] shd_head = '0;
  logic [15:0] shd_tail = '0;
  logic        shd_empty = 1'b1;
  logic [15:0] shd_max_len = rtpb_pkg::MAX_LEN_RST;

  rtpb_pkg::req_t pending_reqs[$];
  rtpb_pkg::rsp_t pending_results[$];
  int   failures = 0;
  int   accepted = 0;
  bit   no_idle = 1'b0;

  initial begin
    for (int i = 0; i < DEPTH; i++) shd_filled[i] = 1'b0;
  end

  // serial difference a - b
  function automatic int serial_diff(logic [15:0] a, logic [15:0] b);
    logic signed [15:0] d;
    d = a - b;
    return int'(d);
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < DEPTH; i++) shd_filled[i] = 1'b0;
  endfunction

  function automatic rtpb_pkg::status_t enqueue_packet(rtpb_pkg::req_t r);
    logic [15:0] s;
    int k;
    if (r.data_len < rtpb_pkg::HDR_LEN || r.data_len > shd_max_len)
      return rtpb_pkg::STAT_BAD_LEN;
    if (r.data_len == rtpb_pkg::MARKER_LEN && r.marker_word == rtpb_pkg::EMPTY_MARKER)
      return rtpb_pkg::STAT_IGNORED;
    s = r.use_seq ? r.seq_in : shd_head;
    if (!shd_empty && serial_diff(s, shd_head) < 0) return rtpb_pkg::STAT_IGNORED;
    // far ahead: restart the window at this packet
    if (serial_diff(s, shd_head + 16'(DEPTH)) >= 0) begin
      clear_store();
      shd_head = s;
      shd_tail = s - 16'd1;
    end
    k = s % DEPTH;
    if (shd_filled[k] && shd_seq[k] == s) return rtpb_pkg::STAT_IGNORED;
    shd_seq[k] = s;
    shd_rtp[k] = r.rtp_time;
    shd_ntp[k] = r.ntp_time;
    shd_len[k] = r.data_len - rtpb_pkg::HDR_LEN;
    shd_tag[k] = r.payload_tag;
    shd_filled[k] = 1'b1;
    if (shd_empty) begin
      shd_head = s;
      shd_tail = s;
      shd_empty = 1'b0;
    end
    if (serial_diff(s, shd_tail) > 0) shd_tail = s;
    return rtpb_pkg::STAT_STORED;
  endfunction

  // expected result beat of one request, updating the shadow store
  function automatic rtpb_pkg::rsp_t predict_result(rtpb_pkg::req_t r);
    rtpb_pkg::rsp_t o;
    int cnt, k;
    logic [15:0] s;
    o = '0;
    case (rtpb_pkg::req_type_t'(r.req_type))
      rtpb_pkg::REQ_ENQ: o.status = enqueue_packet(r);
      rtpb_pkg::REQ_DEQ: begin
        cnt = serial_diff(shd_tail - shd_head + 16'd1, 16'd0);
        k = shd_head % DEPTH;
        if (shd_empty || cnt <= 0) begin
          o.status = rtpb_pkg::STAT_NONE;
        end else if (!r.never_wait && !shd_filled[k] && cnt < DEPTH) begin
          o.status = rtpb_pkg::STAT_NONE;
        end else begin
          shd_head = shd_head + 16'd1;
          if (!shd_filled[k]) begin
            o.status = rtpb_pkg::STAT_SKIPPED;
          end else begin
            shd_filled[k] = 1'b0;
            o.status = rtpb_pkg::STAT_DELIVERED;
            o.out_seq = shd_seq[k];
            o.out_rtp_time = shd_rtp[k];
            o.out_ntp_time = shd_ntp[k];
            o.out_length = shd_len[k];
            o.out_tag = shd_tag[k];
          end
        end
      end
      rtpb_pkg::REQ_RESEND: begin
        s = shd_head;
        o.status = rtpb_pkg::STAT_NO_RESEND;
        if (serial_diff(shd_head, shd_tail) < 0) begin
          while (serial_diff(s, shd_tail) < 0 && !shd_filled[s % DEPTH]) s = s + 16'd1;
          if (s != shd_head) begin
            o.status = rtpb_pkg::STAT_RESEND;
            o.resend_first = shd_head;
            o.resend_count = s - shd_head;
          end
        end
      end
      default: begin
        clear_store();
        if (r.flush_to_empty) begin
          shd_empty = 1'b1;
        end else begin
          shd_head = r.seq_in;
          shd_tail = r.seq_in - 16'd1;
        end
        o.status = rtpb_pkg::STAT_FLUSHED;
      end
    endcase
    return o;
  endfunction

  // request driver with random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        pending_results.push_back(predict_result(req_ch.data));
        accepted++;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the beat
      end else if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 13);
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_reqs.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  // result monitor with random stalls and one long hold-off
  int  recv_gap = 0;
  int  long_hold = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    rtpb_pkg::rsp_t exp_r;
    rtpb_pkg::rsp_t got;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected, status %0d", got.status);
          failures++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("status", exp_r.status, got.status);
          check_field("out_seq", exp_r.out_seq, got.out_seq);
          check_field("out_rtp_time", exp_r.out_rtp_time, got.out_rtp_time);
          check_field("out_ntp_time", exp_r.out_ntp_time, got.out_ntp_time);
          check_field("out_length", exp_r.out_length, got.out_length);
          check_field("out_tag", exp_r.out_tag, got.out_tag);
          check_field("resend_first", exp_r.resend_first, got.resend_first);
          check_field("resend_count", exp_r.resend_count, got.resend_count);
        end
      end
      if (!long_hold_done && accepted >= 300) begin
        long_hold_done = 1'b1;
        long_hold = 500;
      end
      if (long_hold > 0) begin
        long_hold--;
        rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 13);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus generation
  logic [15:0] gen_base = '0;

  function automatic rtpb_pkg::req_t make_req(rtpb_pkg::req_type_t t, logic [15:0] s,
                                              logic [15:0] len);
    rtpb_pkg::req_t r;
    r.req_type = t;
    r.seq_in = s;
    r.use_seq = 1'b1;
    r.data_len = len;
    r.marker_word = $urandom;
    r.rtp_time = {$urandom, $urandom};
    r.ntp_time = {$urandom, $urandom};
    r.payload_tag = 16'($urandom);
    r.never_wait = 1'b0;
    r.flush_to_empty = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] pick_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return 16'($urandom);
    if (p < 8) return 16'($urandom_range(0, 11));
    if (p < 11) return rtpb_pkg::MARKER_LEN;
    if (p < 14) return shd_max_len;
    return 16'($urandom_range(12, (shd_max_len > 1500) ? 1500 : shd_max_len));
  endfunction

  function automatic rtpb_pkg::req_t random_req();
    rtpb_pkg::req_t r;
    int p, q;
    p = $urandom_range(0, 99);
    if (p < 52) begin
      q = $urandom_range(0, 99);
      r = make_req(rtpb_pkg::REQ_ENQ, gen_base, pick_len());
      if (q < 70) r.seq_in = gen_base + 16'($urandom_range(0, 6));
      else if (q < 80) r.seq_in = gen_base - 16'($urandom_range(1, 8));
      else if (q < 90) r.seq_in = gen_base + 16'($urandom_range(7, 40));
      else r.seq_in = 16'($urandom);
      if (r.data_len == rtpb_pkg::MARKER_LEN && $urandom_range(0, 1))
        r.marker_word = rtpb_pkg::EMPTY_MARKER;
      r.use_seq = ($urandom_range(0, 19) != 0);
      if (q >= 90) gen_base = r.seq_in;
      else if ($urandom_range(0, 1)) gen_base = gen_base + 16'd1;
    end else if (p < 88) begin
      r = make_req(rtpb_pkg::REQ_DEQ, 16'($urandom), 16'($urandom));
      r.never_wait = ($urandom_range(0, 3) == 0);
    end else if (p < 97) begin
      r = make_req(rtpb_pkg::REQ_RESEND, 16'($urandom), 16'($urandom));
    end else begin
      r = make_req(rtpb_pkg::REQ_FLUSH, 16'($urandom), 16'($urandom));
      r.flush_to_empty = $urandom_range(0, 1);
      if (!r.flush_to_empty) gen_base = r.seq_in;
    end
    return r;
  endfunction

  task automatic write_max_len(logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_MAX_LEN; pwdata <= {16'($urandom_range(0, 65535)), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    shd_max_len = v;
  endtask

  // sampled at the falling edge so the driver's updates have settled
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_ch.valid || pending_results.size() > 0)
      @(negedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic push_enq(logic [15:0] s, logic [15:0] len);
    pending_reqs.push_back(make_req(rtpb_pkg::REQ_ENQ, s, len));
  endtask

  task automatic push_op(rtpb_pkg::req_type_t t, logic flag, logic [15:0] s);
    rtpb_pkg::req_t r;
    r = make_req(t, s, 16'($urandom));
    r.never_wait = flag;
    r.flush_to_empty = flag;
    pending_reqs.push_back(r);
  endtask

  initial begin
    rtpb_pkg::req_t r;
    logic [15:0] phase_len [5];
    phase_len = '{16'd65535, 16'd12, 16'd1500, 16'd0, 16'd2048};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_max_len(rtpb_pkg::MAX_LEN_RST);

    // directed: lengths, marker, duplicate, late, gaps, wrap, far ahead, flushes
    push_enq(16'd0, 16'd12);
    push_enq(16'd1, 16'd11);
    push_enq(16'd1, 16'd2049);
    r = make_req(rtpb_pkg::REQ_ENQ, 16'd1, rtpb_pkg::MARKER_LEN);
    r.marker_word = rtpb_pkg::EMPTY_MARKER;
    pending_reqs.push_back(r);
    push_enq(16'd0, 16'd2048);
    push_enq(16'd3, 16'd100);
    push_op(rtpb_pkg::REQ_RESEND, 1'b0, 16'd0);
    push_op(rtpb_pkg::REQ_DEQ, 1'b0, 16'd0);
    push_op(rtpb_pkg::REQ_DEQ, 1'b0, 16'd0);
    push_op(rtpb_pkg::REQ_DEQ, 1'b1, 16'd0);
    push_op(rtpb_pkg::REQ_DEQ, 1'b0, 16'd0);
    push_op(rtpb_pkg::REQ_DEQ, 1'b0, 16'd0);
    push_enq(16'd1, 16'd20);
    r = make_req(rtpb_pkg::REQ_ENQ, 16'hffff, 16'd40);
    r.use_seq = 1'b0;
    pending_reqs.push_back(r);
    push_enq(16'd60, 16'd30);
    push_op(rtpb_pkg::REQ_RESEND, 1'b0, 16'd0);
    push_op(rtpb_pkg::REQ_FLUSH, 1'b0, 16'hfffe);
    push_enq(16'hffff, 16'd50);
    push_enq(16'h0000, 16'd50);
    push_op(rtpb_pkg::REQ_DEQ, 1'b1, 16'd0);
    push_op(rtpb_pkg::REQ_DEQ, 1'b1, 16'd0);
    push_op(rtpb_pkg::REQ_DEQ, 1'b1, 16'd0);
    push_op(rtpb_pkg::REQ_FLUSH, 1'b1, 16'd0);
    push_op(rtpb_pkg::REQ_DEQ, 1'b0, 16'd0);
    push_enq(16'h8000, 16'd13);
    wait_drained();

    // random phases under several length limits
    foreach (phase_len[i]) begin
      write_max_len(phase_len[i] == 0 ? 16'($urandom_range(13, 65535)) : phase_len[i]);
      if (i == 4) no_idle = 1'b1;
      for (int n = 0; n < (i == 1 ? 150 : 320); n++) pending_reqs.push_back(random_req());
      wait_drained();
    end

    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
